>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

// Property checked only while reset is released (active-low reset).
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

>>> hw/rtl/lgs_pkg.sv
// Shared types and constants of the life grid generation step block.
package lgs_pkg;

    localparam int OP_W    = 2;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 5;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    // B3/S23 neighbor counts
    localparam logic [3:0] NBR_BIRTH   = 4'd3;
    localparam logic [3:0] NBR_SURVIVE = 4'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_WB,
        S_GEN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic acc_rd;
        logic acc_wb;
        logic gen_start;
        logic gen_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_adv;
        logic gen_last;
    } t_dp_status;

endpackage

>>> hw/rtl/lgs_if.sv
// Valid/ready channel interfaces for commands and results.
interface lgs_in_if import lgs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;

    modport source (output valid, opcode, row, col, value, input ready);
    modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

interface lgs_out_if;
    logic valid;
    logic ready;
    logic cell_state;

    modport source (output valid, cell_state, input ready);
    modport sink   (input valid, cell_state, output ready);
endinterface

>>> hw/rtl/lgs_ram.sv
// Generic one-write, one-read RAM with registered read data.
module lgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/lgs_ctrl.sv
// Controller state machine: handshakes and sequencing of the datapath.
module lgs_ctrl import lgs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                if (i_status.is_adv) begin
                    o_cmd.gen_start = 1'b1;
                    n_state         = S_GEN;
                end else begin
                    o_cmd.acc_rd = 1'b1;
                    n_state      = S_WB;
                end
            end
            S_WB: begin
                o_cmd.acc_wb = 1'b1;
                n_state      = S_DONE;
            end
            S_GEN: begin
                o_cmd.gen_step = 1'b1;
                if (i_status.gen_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

>>> hw/rtl/lgs_datapath.sv
// Datapath: grid row memory, row valid bits, three-row window and result registers.
module lgs_datapath import lgs_pkg::*; #(
    parameter int COLS = 32,
    parameter int ROWS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    input  logic             i_value,
    output t_dp_status       o_status,
    output logic             o_cell_state
);
    localparam int AW = $clog2(ROWS);
    localparam int CW = $clog2(ROWS + 2);

    logic [OP_W-1:0]  r_op;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_val;
    logic [CW-1:0]    r_cnt;
    logic [COLS-1:0]  r_top, r_mid;
    logic [ROWS-1:0]  r_valid;
    logic             r_rd_vld;
    logic             r_res;
    logic             r_out;

    logic            w_inside;
    logic            w_re, w_we;
    logic [AW-1:0]   w_raddr, w_waddr;
    logic [COLS-1:0] w_wdata, w_rdata, w_row;
    logic [COLS-1:0] w_below, w_next, w_mask, w_acc_sh, w_gen_sh;
    logic [COLS+1:0] w_pt, w_pm, w_pb;
    logic [3:0]      w_n [COLS];
    logic            w_gen_wr, w_gen_rd, w_gen_hit;

    assign w_inside = (32'(r_row) < ROWS) && (32'(r_col) < COLS);
    assign w_row    = w_rdata & {COLS{r_rd_vld}};
    assign w_mask   = {{(COLS-1){1'b0}}, 1'b1} << r_col;
    assign w_acc_sh = w_row >> r_col;

    // generation window: row r_cnt-2 is computed from rows r_cnt-3..r_cnt-1
    assign w_gen_rd  = (32'(r_cnt) < ROWS);
    assign w_gen_wr  = (r_cnt >= CW'(2));
    assign w_below   = (r_cnt >= CW'(1) && 32'(r_cnt) <= ROWS) ? w_row : '0;
    assign w_pt      = {1'b0, r_top, 1'b0};
    assign w_pm      = {1'b0, r_mid, 1'b0};
    assign w_pb      = {1'b0, w_below, 1'b0};
    assign w_gen_sh  = w_next >> r_col;
    assign w_gen_hit = w_gen_wr && w_inside && (w_waddr == AW'(r_row));

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            w_n[c] = 4'(w_pt[c]) + 4'(w_pt[c+1]) + 4'(w_pt[c+2])
                   + 4'(w_pm[c]) + 4'(w_pm[c+2])
                   + 4'(w_pb[c]) + 4'(w_pb[c+1]) + 4'(w_pb[c+2]);
            w_next[c] = (w_n[c] == NBR_BIRTH) || (w_pm[c+1] && (w_n[c] == NBR_SURVIVE));
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = AW'(r_row);
        w_we    = 1'b0;
        w_waddr = AW'(r_row);
        w_wdata = r_val ? (w_row | w_mask) : (w_row & ~w_mask);
        if (i_cmd.acc_rd) begin
            w_re = w_inside;
        end
        if (i_cmd.acc_wb) begin
            w_we = w_inside && (r_op == OP_WRITE);
        end
        if (i_cmd.gen_step) begin
            w_re    = w_gen_rd;
            w_raddr = AW'(r_cnt);
            w_we    = w_gen_wr;
            w_waddr = AW'(r_cnt - CW'(2));
            w_wdata = w_next;
        end
    end

    lgs_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_lgs_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // a row never written reads as all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_vld <= r_valid[w_raddr];
        end
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_row <= i_row;
            r_col <= i_col;
            r_val <= i_value;
        end
        if (i_cmd.gen_start) begin
            r_cnt <= '0;
            r_top <= '0;
            r_mid <= '0;
            r_res <= 1'b0;
        end
        if (i_cmd.gen_step) begin
            r_cnt <= r_cnt + CW'(1);
            r_top <= r_mid;
            r_mid <= w_below;
            if (w_gen_hit) begin
                r_res <= w_gen_sh[0];
            end
        end
        if (i_cmd.acc_wb) begin
            if (!w_inside) begin
                r_res <= 1'b0;
            end else if (r_op == OP_WRITE) begin
                r_res <= r_val;
            end else begin
                r_res <= w_acc_sh[0];
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_status.is_adv   = (r_op == OP_ADVANCE);
    assign o_status.gen_last = (r_cnt == CW'(ROWS + 1));
    assign o_cell_state      = r_out;
endmodule

>>> hw/rtl/life_grid_generation_step_core.sv
// Top level of the B3/S23 life grid: controller, datapath and channel ports.
//
// i_cmd carries one command per transfer: write a cell, read a cell, or
// advance the whole ROWS x COLS grid by one generation (opcode 3 reads).
// o_res returns exactly one transfer per command with the addressed cell's
// state after the command; an address outside the grid returns 0.
// One command is in work at a time; i_cmd.ready is high while idle.
// Read and write pass from S_ACC (row read) through S_WB (cell update
// and result) to S_DONE, which loads the output register; the next
// command is taken once the controller is back in S_IDLE. Advance goes
// from S_ACC through S_GEN to S_DONE; S_GEN is the row
// sweep that reads one grid row per cycle from the row memory through a
// three-row window and writes back each new row once the row below it is read.
// Reset clears all cells to dead at once through per-row valid bits and
// drops any pending result. When o_res.ready is low the result holds in
// the output register; the block still takes the next command and stalls
// only at the end of that command until the output register frees up.
module life_grid_generation_step_core import lgs_pkg::*; #(
    parameter int COLS = 32,
    parameter int ROWS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lgs_in_if.sink    i_cmd,
    lgs_out_if.source o_res
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;
    logic       w_cell_state;

    lgs_ctrl u_lgs_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lgs_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_lgs_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_opcode     (i_cmd.opcode),
        .i_row        (i_cmd.row),
        .i_col        (i_cmd.col),
        .i_value      (i_cmd.value),
        .o_status     (w_status),
        .o_cell_state (w_cell_state)
    );

    assign i_cmd.ready      = w_in_ready;
    assign o_res.valid      = w_out_valid;
    assign o_res.cell_state = w_cell_state;
endmodule

>>> hw/rtl/lgs_checker.sv
// Port-level checker for the life grid core and its bind.
`include "assert_macros.svh"

module lgs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_cell_state
);
    // no result survives reset
    `ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

    // a stalled result holds its value
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cell_state))

    // one command in work at a time
    `ASSERT_RST(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    // a new result appears only at the end of a command in work
    `ASSERT_RST(a_out_after_busy, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(!i_in_ready))
endmodule

bind life_grid_generation_step_core lgs_checker u_lgs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_cell_state (o_res.cell_state)
);

>>> dv/tb_top.sv
// Self-checking testbench for the B3/S23 life grid core: cell writes, reads and generation steps.
module tb_top import lgs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_ROWS  = 16;
    localparam int GRID_COLS  = 32;
    localparam int NUM_ITEMS  = 1700;
    localparam int DRAIN_CYC  = 40;
    localparam int MAX_REPORT = 200;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             value;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             state;
    } t_cell_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lgs_in_if  cmd_if ();
    lgs_out_if res_if ();

    life_grid_generation_step_core #(
        .COLS (GRID_COLS),
        .ROWS (GRID_ROWS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_cmd                     pending_cmds [$];
    t_cell_result             cells_due    [$];
    logic [GRID_COLS-1:0]     life_grid    [GRID_ROWS];
    t_cmd                     next_cmd;
    bit                       cmd_taken;
    int                       n_issued;
    int                       n_total;
    int                       n_errors;

    // Cells beyond the grid edges count as dead: no wrap across rows or columns.
    function automatic void advance_generation();
        logic [GRID_COLS-1:0] old_rows [GRID_ROWS];
        int nbrs;
        int rr;
        int cc;
        old_rows = life_grid;
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                            cc >= 0 && cc < GRID_COLS)
                            nbrs += old_rows[rr][cc];
                    end
                end
                life_grid[r][c] = (nbrs == NBR_BIRTH) ||
                                  (old_rows[r][c] && nbrs == NBR_SURVIVE);
            end
        end
    endfunction

    function automatic logic apply_cmd(t_cmd c);
        logic inside_grid;
        inside_grid = (c.row < GRID_ROWS) && (c.col < GRID_COLS);
        case (c.op)
            OP_WRITE: begin
                if (inside_grid)
                    life_grid[c.row][c.col] = c.value;
            end
            OP_ADVANCE: begin
                advance_generation();
            end
            default: ;
        endcase
        return inside_grid ? life_grid[c.row][c.col] : 1'b0;
    endfunction

    task automatic add_cmd(logic [OP_W-1:0] op, int row, int col, logic value);
        t_cmd c;
        c.op    = op;
        c.row   = row[ROW_W-1:0];
        c.col   = col[COL_W-1:0];
        c.value = value;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    function automatic int tx_idle_pct();
        int phase;
        phase = (n_issued * 3) / n_total;
        return (phase == 0) ? 15 : (phase == 1) ? 56 : 0;
    endfunction

    function automatic int rx_idle_pct();
        int phase;
        phase = (n_issued * 3) / n_total;
        return (phase == 0) ? 56 : (phase == 1) ? 15 : 0;
    endfunction

    // Drive at the falling edge; hold an item until its transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
                next_cmd = pending_cmds.pop_front();
                cmd_if.opcode <= next_cmd.op;
                cmd_if.row    <= next_cmd.row;
                cmd_if.col    <= next_cmd.col;
                cmd_if.value  <= next_cmd.value;
                cmd_if.valid  <= 1'b1;
                n_issued++;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
        res_if.ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct());
    end

    // Sample at the rising edge: predict on command transfers, check result transfers.
    always @(posedge i_clk) begin
        t_cell_result due;
        t_cmd         acc;
        cmd_taken = i_rst_n && cmd_if.valid && cmd_if.ready;
        if (cmd_taken) begin
            acc.op    = cmd_if.opcode;
            acc.row   = cmd_if.row;
            acc.col   = cmd_if.col;
            acc.value = cmd_if.value;
            due.row   = acc.row;
            due.col   = acc.col;
            due.state = apply_cmd(acc);
            cells_due.insert(cells_due.size(), due);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (cells_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORT)
                    $display("%0t: unexpected result transfer, cell_state %0b",
                             $realtime, res_if.cell_state);
            end else begin
                due = cells_due.pop_front();
                if (res_if.cell_state !== due.state) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORT)
                        $display("%0t: cell (%0d,%0d) expected %0b, got %0b", $realtime,
                                 due.row, due.col, due.state, res_if.cell_state);
                end
            end
        end
    end

    initial begin
        int ctr_r;
        int ctr_c;
        int pick;
        int wr_row;
        int wr_col;

        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.opcode = OP_READ;
        cmd_if.row    = '0;
        cmd_if.col    = '0;
        cmd_if.value  = 1'b0;
        res_if.ready  = 1'b0;
        cmd_taken     = 1'b0;
        n_issued      = 0;
        n_errors      = 0;
        for (int r = 0; r < GRID_ROWS; r++)
            life_grid[r] = '0;

        // Directed: cleared grid, blinkers on the right and bottom edges, unused opcode.
        add_cmd(OP_READ, 0, 0, 1'b0);
        add_cmd(OP_WRITE, 5, 31, 1'b1);
        add_cmd(OP_WRITE, 6, 31, 1'b1);
        add_cmd(OP_WRITE, 7, 31, 1'b1);
        add_cmd(OP_WRITE, 15, 10, 1'b1);
        add_cmd(OP_WRITE, 15, 11, 1'b1);
        add_cmd(OP_WRITE, 15, 12, 1'b1);
        add_cmd(OP_WRITE, 0, 0, 1'b1);
        add_cmd(OP_WRITE, 0, 0, 1'b0);
        add_cmd(OP_UNUSED, 6, 31, 1'b0);
        // A wrap across the row end or past the last row would give birth here.
        add_cmd(OP_ADVANCE, 6, 0, 1'b0);
        add_cmd(OP_READ, 0, 11, 1'b0);
        add_cmd(OP_READ, 6, 30, 1'b0);
        add_cmd(OP_READ, 14, 11, 1'b0);
        add_cmd(OP_ADVANCE, 15, 31, 1'b1);
        add_cmd(OP_WRITE, 9, 20, 1'b1);
        add_cmd(OP_WRITE, 9, 20, 1'b0);
        add_cmd(OP_UNUSED, 9, 20, 1'b1);
        add_cmd(OP_READ, 9, 20, 1'b0);
        add_cmd(OP_ADVANCE, 0, 0, 1'b0);

        // Random: seed clusters so the generations have structure to work on.
        ctr_r = $urandom_range(GRID_ROWS - 1);
        ctr_c = $urandom_range(GRID_COLS - 1);
        while (pending_cmds.size() < NUM_ITEMS) begin
            pick = $urandom_range(99);
            if ($urandom_range(39) == 0) begin
                ctr_r = $urandom_range(GRID_ROWS - 1);
                ctr_c = $urandom_range(GRID_COLS - 1);
            end
            if (pick < 60) begin
                if ($urandom_range(1)) begin
                    wr_row = (ctr_r + $urandom_range(4)) % GRID_ROWS;
                    wr_col = (ctr_c + $urandom_range(4)) % GRID_COLS;
                end else begin
                    wr_row = $urandom_range(GRID_ROWS - 1);
                    wr_col = $urandom_range(GRID_COLS - 1);
                end
                add_cmd(OP_WRITE, wr_row, wr_col, $urandom_range(99) < 65);
            end else if (pick < 78) begin
                add_cmd(OP_READ, $urandom_range(GRID_ROWS - 1),
                        $urandom_range(GRID_COLS - 1), 1'($urandom_range(1)));
            end else if (pick < 83) begin
                add_cmd(OP_UNUSED, $urandom_range(GRID_ROWS - 1),
                        $urandom_range(GRID_COLS - 1), 1'($urandom_range(1)));
            end else begin
                add_cmd(OP_ADVANCE, $urandom_range(GRID_ROWS - 1),
                        $urandom_range(GRID_COLS - 1), 1'($urandom_range(1)));
            end
        end
        n_total = pending_cmds.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || cells_due.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
